// ===== rtl/mffrq_pkg.sv =====
// Package for the mesh frame filter relay queue.
// Holds parameter defaults, field widths, status, request and register codes.
// No dependencies; every other file but mffrq_ram imports it.
package mffrq_pkg;

    // Defaults for the top-level parameters
    localparam int QUEUE_SLOTS_DEF = 16;
    localparam int MAX_PAYLOAD_DEF = 64;
    localparam int FRAME_BYTES_DEF = 70;

    // Fixed field widths
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Frame layout: byte 0 address, byte 3 network, byte 4 direction, byte 5 size
    localparam int MIN_FRAME_BYTES = 4;
    localparam int HEADER_BYTES    = 6;
    localparam int END_OFFSET      = 5;

    localparam logic [COUNT_W-1:0] QUEUE_LIMIT_RESET = 4'd10;

    typedef enum logic [1:0] {
        REQ_RX    = 2'd0,
        REQ_FETCH = 2'd1,
        REQ_POP   = 2'd2
    } req_t;

    typedef enum logic [3:0] {
        STAT_TAKEN   = 4'd0,
        STAT_QUEUED  = 4'd1,
        STAT_CLUSTER = 4'd2,
        STAT_NETWORK = 4'd3,
        STAT_LENGTH  = 4'd4,
        STAT_FULL    = 4'd5,
        STAT_TXBYTE  = 4'd6,
        STAT_EMPTY   = 4'd7,
        STAT_POPPED  = 4'd8
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_CLUSTER = 3'd0,
        CFG_NETWORK     = 3'd1,
        CFG_GATEWAY_HOP = 3'd2,
        CFG_NODE_HOP    = 3'd3,
        CFG_QUEUE_LIMIT = 3'd4
    } cfg_reg_t;

    // Configuration register set handed to the controller
    typedef struct packed {
        logic [BYTE_W-1:0]  own_cluster_id;
        logic [BYTE_W-1:0]  network_id;
        logic [BYTE_W-1:0]  gateway_hop_id;
        logic [BYTE_W-1:0]  node_hop_id;
        logic [COUNT_W-1:0] queue_limit;
    } cfg_t;

endpackage

// ===== rtl/mffrq_req_if.sv =====
// Request channel: valid/ready handshake with the request beat payload.
// Depends on mffrq_pkg for field widths.
interface mffrq_req_if
    import mffrq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_last;

    modport source (output valid, req_type, rx_byte, rx_last, input ready);
    modport sink   (input valid, req_type, rx_byte, rx_last, output ready);
endinterface

// ===== rtl/mffrq_rsp_if.sv =====
// Response channel: valid/ready handshake with the result beat payload.
// Depends on mffrq_pkg for field widths.
interface mffrq_rsp_if
    import mffrq_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [3:0]         status;
    logic [BYTE_W-1:0]  tx_byte;
    logic               tx_last;
    logic [COUNT_W-1:0] queue_count;

    modport source (output valid, status, tx_byte, tx_last, queue_count, input ready);
    modport sink   (input valid, status, tx_byte, tx_last, queue_count, output ready);
endinterface

// ===== rtl/mffrq_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Used for the frame byte store and the per-slot frame descriptors.
module mffrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/mffrq_ctrl.sv =====
// Queue controller: receive filtering, slot bookkeeping, transmit readout, result register.
// Depends on mffrq_pkg and the req/rsp interfaces; drives the two mffrq_ram instances.
module mffrq_ctrl
    import mffrq_pkg::*;
#(
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    localparam int SLOT_W = $clog2(QUEUE_SLOTS),
    localparam int IDX_W  = $clog2(FRAME_BYTES),
    localparam int ADDR_W = $clog2(QUEUE_SLOTS * FRAME_BYTES),
    localparam int META_W = IDX_W + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    mffrq_req_if.sink          req,
    mffrq_rsp_if.source        rsp,
    // frame byte store
    output logic               data_we,
    output logic [ADDR_W-1:0]  data_waddr,
    output logic [BYTE_W-1:0]  data_wdata,
    output logic               data_re,
    output logic [ADDR_W-1:0]  data_raddr,
    input  logic [BYTE_W-1:0]  data_rdata,
    // slot descriptors: {direction nonzero, index of final byte}
    output logic               meta_we,
    output logic [SLOT_W-1:0]  meta_waddr,
    output logic [META_W-1:0]  meta_wdata,
    output logic               meta_re,
    output logic [SLOT_W-1:0]  meta_raddr,
    input  logic [META_W-1:0]  meta_rdata
);
    localparam int CNT_W = $clog2(FRAME_BYTES + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [SLOT_W-1:0]   tail_reg, tail_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]    rx_index_reg, rx_index_next;
    logic                rx_bad_cluster_reg, rx_bad_cluster_next;
    logic                rx_bad_network_reg, rx_bad_network_next;
    logic [BYTE_W-1:0]   rx_size_reg, rx_size_next;
    logic                rx_dir_reg, rx_dir_next;
    logic [IDX_W-1:0]    tx_index_reg, tx_index_next;
    // latched request beat
    logic [1:0]          rq_type_reg, rq_type_next;
    logic [BYTE_W-1:0]   rq_byte_reg, rq_byte_next;
    logic                rq_last_reg, rq_last_next;
    // result register
    logic                out_valid_reg, out_valid_next;
    logic [3:0]          out_status_reg, out_status_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    logic                accept;
    logic                out_free;
    logic                commit;
    logic [CNT_W-1:0]    rx_count;
    logic                bad_cluster, bad_network;
    logic [BYTE_W-1:0]   size_now;
    logic                dir_now;
    logic [BYTE_W:0]     end_sum;
    logic [IDX_W-1:0]    rx_end;
    logic                queue_full;
    logic [IDX_W-1:0]    meta_end;
    logic                meta_dir;
    logic [IDX_W-1:0]    tx_pos;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [SLOT_W-1:0] slot,
                                                  input logic [IDX_W-1:0]  idx);
        return ADDR_W'(slot) * ADDR_W'(FRAME_BYTES) + ADDR_W'(idx);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
        return (slot == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : slot + SLOT_W'(1);
    endfunction

    // Handshake: one request in flight; the result register frees the input side
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign commit    = (state_reg == S_EXEC) && out_free;

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.tx_byte     = out_byte_reg;
    assign rsp.tx_last     = out_last_reg;
    assign rsp.queue_count = out_count_reg;

    // Reads are launched at accept; head and tx position cannot move before use
    assign data_re    = accept;
    assign data_raddr = addr_of(head_reg, tx_index_reg);
    assign meta_re    = accept;
    assign meta_raddr = head_reg;

    // Receive path terms
    assign rx_count    = (rx_index_reg == CNT_W'(FRAME_BYTES)) ? rx_index_reg
                                                                : rx_index_reg + CNT_W'(1);
    assign bad_cluster = rx_bad_cluster_reg
                         || (rx_index_reg == '0 && rq_byte_reg != cfg.own_cluster_id);
    assign bad_network = rx_bad_network_reg
                         || (rx_index_reg == CNT_W'(3) && rq_byte_reg != cfg.network_id);
    assign size_now    = (rx_index_reg == CNT_W'(END_OFFSET)) ? rq_byte_reg : rx_size_reg;
    assign dir_now     = (rx_index_reg == CNT_W'(4)) ? (rq_byte_reg != '0) : rx_dir_reg;
    assign end_sum     = (BYTE_W + 1)'(size_now) + (BYTE_W + 1)'(END_OFFSET);
    assign rx_end      = (int'(end_sum) > FRAME_BYTES - 1) ? IDX_W'(FRAME_BYTES - 1)
                                                            : end_sum[IDX_W-1:0];
    assign queue_full  = (count_reg >= cfg.queue_limit)
                         || (int'(count_reg) >= QUEUE_SLOTS - 1);

    // Transmit path terms
    assign meta_end = meta_rdata[IDX_W-1:0];
    assign meta_dir = meta_rdata[IDX_W];
    assign tx_pos   = (tx_index_reg > meta_end) ? '0 : tx_index_reg;

    // Store writes happen only on the committing cycle of a receive beat
    assign data_we    = commit && (req_t'(rq_type_reg) == REQ_RX)
                        && (rx_index_reg < CNT_W'(FRAME_BYTES));
    assign data_waddr = addr_of(tail_reg, rx_index_reg[IDX_W-1:0]);
    assign data_wdata = rq_byte_reg;
    assign meta_waddr = tail_reg;
    assign meta_wdata = {dir_now, rx_end};

    // Next-state logic
    always_comb
    begin
        state_next          = state_reg;
        head_next           = head_reg;
        tail_next           = tail_reg;
        count_next          = count_reg;
        rx_index_next       = rx_index_reg;
        rx_bad_cluster_next = rx_bad_cluster_reg;
        rx_bad_network_next = rx_bad_network_reg;
        rx_size_next        = rx_size_reg;
        rx_dir_next         = rx_dir_reg;
        tx_index_next       = tx_index_reg;
        rq_type_next        = rq_type_reg;
        rq_byte_next        = rq_byte_reg;
        rq_last_next        = rq_last_reg;
        out_valid_next      = out_valid_reg && !rsp.ready;
        out_status_next     = out_status_reg;
        out_byte_next       = out_byte_reg;
        out_last_next       = out_last_reg;
        out_count_next      = out_count_reg;
        meta_we             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rq_type_next = req.req_type;
                    rq_byte_next = req.rx_byte;
                    rq_last_next = req.rx_last;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_TAKEN;
                    out_byte_next   = '0;
                    out_last_next   = 1'b0;
                    case (req_t'(rq_type_reg))
                        REQ_RX:
                        begin
                            if (!rq_last_reg)
                            begin
                                rx_index_next       = rx_count;
                                rx_bad_cluster_next = bad_cluster;
                                rx_bad_network_next = bad_network;
                                rx_size_next        = size_now;
                                rx_dir_next         = dir_now;
                            end
                            else
                            begin
                                if (int'(rx_count) < MIN_FRAME_BYTES)
                                    out_status_next = STAT_LENGTH;
                                else if (bad_cluster)
                                    out_status_next = STAT_CLUSTER;
                                else if (bad_network)
                                    out_status_next = STAT_NETWORK;
                                else if (int'(size_now) > MAX_PAYLOAD
                                         || int'(rx_count) < HEADER_BYTES + int'(size_now))
                                    out_status_next = STAT_LENGTH;
                                else if (queue_full)
                                    out_status_next = STAT_FULL;
                                else
                                begin
                                    meta_we         = 1'b1;
                                    tail_next       = slot_inc(tail_reg);
                                    count_next      = count_reg + COUNT_W'(1);
                                    out_status_next = STAT_QUEUED;
                                end
                                rx_index_next       = '0;
                                rx_bad_cluster_next = 1'b0;
                                rx_bad_network_next = 1'b0;
                                rx_size_next        = '0;
                                rx_dir_next         = 1'b0;
                            end
                        end
                        REQ_FETCH:
                        begin
                            if (count_reg == '0)
                                out_status_next = STAT_EMPTY;
                            else
                            begin
                                out_status_next = STAT_TXBYTE;
                                // byte 0 carries the next hop picked by direction
                                if (tx_pos == '0)
                                    out_byte_next = meta_dir ? cfg.node_hop_id
                                                             : cfg.gateway_hop_id;
                                else
                                    out_byte_next = data_rdata;
                                if (tx_pos == meta_end)
                                begin
                                    out_last_next = 1'b1;
                                    tx_index_next = '0;
                                end
                                else
                                    tx_index_next = tx_pos + IDX_W'(1);
                            end
                        end
                        REQ_POP:
                        begin
                            if (count_reg == '0)
                                out_status_next = STAT_EMPTY;
                            else
                            begin
                                head_next       = slot_inc(head_reg);
                                count_next      = count_reg - COUNT_W'(1);
                                tx_index_next   = '0;
                                out_status_next = STAT_POPPED;
                            end
                        end
                        default:
                        begin
                            out_status_next = STAT_TAKEN;
                        end
                    endcase
                    out_count_next = count_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            head_reg           <= '0;
            tail_reg           <= '0;
            count_reg          <= '0;
            rx_index_reg       <= '0;
            rx_bad_cluster_reg <= 1'b0;
            rx_bad_network_reg <= 1'b0;
            rx_size_reg        <= '0;
            rx_dir_reg         <= 1'b0;
            tx_index_reg       <= '0;
            rq_type_reg        <= '0;
            rq_byte_reg        <= '0;
            rq_last_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_status_reg     <= STAT_TAKEN;
            out_byte_reg       <= '0;
            out_last_reg       <= 1'b0;
            out_count_reg      <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            head_reg           <= head_next;
            tail_reg           <= tail_next;
            count_reg          <= count_next;
            rx_index_reg       <= rx_index_next;
            rx_bad_cluster_reg <= rx_bad_cluster_next;
            rx_bad_network_reg <= rx_bad_network_next;
            rx_size_reg        <= rx_size_next;
            rx_dir_reg         <= rx_dir_next;
            tx_index_reg       <= tx_index_next;
            rq_type_reg        <= rq_type_next;
            rq_byte_reg        <= rq_byte_next;
            rq_last_reg        <= rq_last_next;
            out_valid_reg      <= out_valid_next;
            out_status_reg     <= out_status_next;
            out_byte_reg       <= out_byte_next;
            out_last_reg       <= out_last_next;
            out_count_reg      <= out_count_next;
        end
    end

    // Held frames never reach the slot being filled
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= QUEUE_SLOTS - 1)
        else $error("frame count exceeds usable slots");

    // Tail sits count slots ahead of head
    a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        ((int'(head_reg) + int'(count_reg) >= QUEUE_SLOTS)
            ? int'(head_reg) + int'(count_reg) - QUEUE_SLOTS
            : int'(head_reg) + int'(count_reg)) == int'(tail_reg))
        else $error("head, tail and count disagree");

    // A committed request returns the controller to idle with a result pending
    a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (state_reg == S_IDLE) && out_valid_reg)
        else $error("commit did not produce a result");

    // Receive position saturates at the slot size
    a_rx_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(rx_index_reg) <= FRAME_BYTES)
        else $error("receive index beyond slot size");
endmodule

// ===== rtl/mesh_frame_filter_relay_queue_top.sv =====
// Top level of the mesh frame filter relay queue: configuration registers,
// controller and the two store memories. Depends on mffrq_pkg, the interfaces,
// mffrq_ram and mffrq_ctrl.
//
//  Channel   Dir  Handshake        Beat contents
//  req       in   valid/ready      req_type, rx_byte, rx_last
//  rsp       out  valid/ready      status, tx_byte, tx_last, queue_count
//  cfg       in   cfg_we only      cfg_index, cfg_data
//
// Each request beat has two steps: an idle step that launches the store and descriptor
// reads, and an execute step that consumes the registered read data and updates the queue.
// A result waits in an output register; the next request is taken meanwhile,
// and the controller stalls in its execute step only while that register is full.
// Reset clears the queue pointers and counters at once; the byte store is not
// cleared, since a held frame is always completely written before it is read.
module mesh_frame_filter_relay_queue_top
    import mffrq_pkg::*;
#(
    parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mffrq_req_if.sink             req,
    mffrq_rsp_if.source           rsp
);
    localparam int SLOT_W = $clog2(QUEUE_SLOTS);
    localparam int IDX_W  = $clog2(FRAME_BYTES);
    localparam int ADDR_W = $clog2(QUEUE_SLOTS * FRAME_BYTES);
    localparam int META_W = IDX_W + 1;

    cfg_t               cfg_reg;
    logic               data_we, data_re, meta_we, meta_re;
    logic [ADDR_W-1:0]  data_waddr, data_raddr;
    logic [BYTE_W-1:0]  data_wdata, data_rdata;
    logic [SLOT_W-1:0]  meta_waddr, meta_raddr;
    logic [META_W-1:0]  meta_wdata, meta_rdata;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_cluster_id <= '0;
            cfg_reg.network_id     <= '0;
            cfg_reg.gateway_hop_id <= '0;
            cfg_reg.node_hop_id    <= '0;
            cfg_reg.queue_limit    <= QUEUE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_OWN_CLUSTER: cfg_reg.own_cluster_id <= cfg_data;
                CFG_NETWORK:     cfg_reg.network_id     <= cfg_data;
                CFG_GATEWAY_HOP: cfg_reg.gateway_hop_id <= cfg_data;
                CFG_NODE_HOP:    cfg_reg.node_hop_id    <= cfg_data;
                CFG_QUEUE_LIMIT: cfg_reg.queue_limit    <= cfg_data[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    mffrq_ctrl #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .req        (req),
        .rsp        (rsp),
        .data_we    (data_we),
        .data_waddr (data_waddr),
        .data_wdata (data_wdata),
        .data_re    (data_re),
        .data_raddr (data_raddr),
        .data_rdata (data_rdata),
        .meta_we    (meta_we),
        .meta_waddr (meta_waddr),
        .meta_wdata (meta_wdata),
        .meta_re    (meta_re),
        .meta_raddr (meta_raddr),
        .meta_rdata (meta_rdata)
    );

    // Frame bytes, one slot of FRAME_BYTES per queue entry
    mffrq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (QUEUE_SLOTS * FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    // Per-slot descriptor: direction flag and final byte index
    mffrq_ram #(
        .WIDTH (META_W),
        .DEPTH (QUEUE_SLOTS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );
endmodule
